// ===== sv/acmac_pkg.sv =====
`default_nettype none
package acmac_pkg;

    typedef logic [127:0] t_blk;

    typedef struct packed {
        logic [127:0] data;
        logic [4:0]   valid_bytes;
        logic         last;
        logic         check;
        logic [127:0] expected;
    } t_item;

    localparam logic [7:0] RB       = 8'h87;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [4:0] FULL_BLK = 5'd16;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] bget(input t_blk b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic t_blk aes_round(input t_blk s, input t_blk k, input logic fin);
        t_blk t;
        t_blk m;
        logic [7:0] a0, a1, a2, a3, al;
        t = '0;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = sbox(bget(s, r + 4 * ((c + r) % 4)));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = bget(t, 4 * c);
            a1 = bget(t, 4 * c + 1);
            a2 = bget(t, 4 * c + 2);
            a3 = bget(t, 4 * c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 32 * c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
            m[119 - 32 * c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
            m[111 - 32 * c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
            m[103 - 32 * c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return (fin ? t : m) ^ k;
    endfunction

    function automatic t_blk key_next(input t_blk k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tt;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tt = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tt;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] rcon_next(input logic [7:0] rc);
        return xtime(rc);
    endfunction

    function automatic t_blk dbl(input t_blk x);
        return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? RB : 8'h00)};
    endfunction

endpackage
`default_nettype wire

// ===== sv/acmac_front.sv =====
`default_nettype none
module acmac_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire acmac_pkg::t_item i_item,
    output logic                o_q_valid,
    input  wire                 i_q_pop,
    output acmac_pkg::t_item    o_q_item
);
    // two-entry queue between the input side and the cipher
    acmac_pkg::t_item r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/acmac_back.sv =====
`default_nettype none
module acmac_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [127:0]           i_key,
    input  wire                   i_key_wr,
    input  wire                   i_q_valid,
    output logic                  o_q_pop,
    input  wire acmac_pkg::t_item i_q_item,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [127:0]          o_tag,
    output logic                  o_match
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEXP = 3'd1;
    localparam logic [2:0] S_LENC = 3'd2;
    localparam logic [2:0] S_SUBK = 3'd3;
    localparam logic [2:0] S_ENC  = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [3:0]   r_rnd;
    logic [7:0]   r_rc;
    acmac_pkg::t_blk r_kcur;
    acmac_pkg::t_blk r_rk [0:10];
    acmac_pkg::t_blk r_st, r_chain, r_k1, r_k2, r_exp, r_rkq;
    logic         r_ready, r_last, r_check;
    acmac_pkg::t_blk w_in, w_pad;
    logic [4:0]   w_cnt;
    logic         w_start;

    // cipher input: final block masked with K1 or padded and masked with K2, then xor chain
    always_comb begin
        w_cnt = (i_q_item.valid_bytes > acmac_pkg::FULL_BLK) ? acmac_pkg::FULL_BLK
                                                             : i_q_item.valid_bytes;
        w_pad = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < w_cnt) begin
                w_pad[127 - 8 * i -: 8] = acmac_pkg::bget(i_q_item.data, i);
            end else if (i == w_cnt) begin
                w_pad[127 - 8 * i -: 8] = acmac_pkg::PAD_MARK;
            end
        end
        if (!i_q_item.last) begin
            w_in = i_q_item.data;
        end else if (w_cnt == acmac_pkg::FULL_BLK) begin
            w_in = i_q_item.data ^ r_k1;
        end else begin
            w_in = w_pad ^ r_k2;
        end
        w_in = w_in ^ r_chain;
    end

    assign w_start = (r_state == S_IDLE) && i_q_valid && r_ready && !o_valid;
    assign o_q_pop = w_start;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_ready && !o_valid) begin
                    n_state = S_KEXP;
                end else if (w_start) begin
                    n_state = S_ENC;
                end
            end
            S_KEXP: if (r_rnd == 4'd10) n_state = S_LENC;
            S_LENC: if (r_rnd == 4'd10) n_state = S_SUBK;
            S_SUBK: n_state = S_IDLE;
            S_ENC:  if (r_rnd == 4'd10) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kcur <= i_key;
                r_rc   <= 8'h01;
                r_rk[0] <= i_key;
                r_rnd  <= 4'd1;
                r_st   <= w_in ^ r_rk[0];
                r_rkq  <= r_rk[1];
                r_last <= i_q_item.last;
                r_check <= i_q_item.check;
                r_exp  <= i_q_item.expected;
            end
            S_KEXP: begin
                r_kcur <= acmac_pkg::key_next(r_kcur, r_rc);
                r_rk[r_rnd] <= acmac_pkg::key_next(r_kcur, r_rc);
                r_rc   <= acmac_pkg::rcon_next(r_rc);
                if (r_rnd == 4'd10) begin
                    r_rnd <= 4'd1;
                    r_st  <= r_rk[0];
                    r_rkq <= r_rk[1];
                end else begin
                    r_rnd <= r_rnd + 4'd1;
                end
            end
            S_LENC, S_ENC: begin
                r_st  <= acmac_pkg::aes_round(r_st, r_rkq, r_rnd == 4'd10);
                r_rkq <= r_rk[(r_rnd == 4'd10) ? 4'd10 : r_rnd + 4'd1];
                r_rnd <= r_rnd + 4'd1;
            end
            S_SUBK: begin
                r_k1 <= acmac_pkg::dbl(r_st);
                r_k2 <= acmac_pkg::dbl(acmac_pkg::dbl(r_st));
            end
            default: ;
        endcase
        if (r_state == S_ENC && r_rnd == 4'd10) begin
            o_tag   <= acmac_pkg::aes_round(r_st, r_rkq, 1'b1);
            o_match <= r_check &&
                       (acmac_pkg::aes_round(r_st, r_rkq, 1'b1) == r_exp);
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_chain <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_key_wr) begin
                r_ready <= 1'b0;
            end else if (r_state == S_SUBK) begin
                r_ready <= 1'b1;
            end
            if (r_state == S_ENC && r_rnd == 4'd10) begin
                r_chain <= r_last ? '0 : acmac_pkg::aes_round(r_st, r_rkq, 1'b1);
                o_valid <= r_last;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/aes_cmac_tag_engine.sv =====
`default_nettype none
// AES-128 CMAC engine. Write the key through the config port, then stream 16-byte
// message blocks; the last block returns the tag and optional match flag. A small
// input queue takes blocks while the cipher works. Each block passes through the
// cipher as one dispatch step that adds the first round key, then ten rounds of the
// one-round-per-cycle AES unit; CBC chaining serializes blocks. A final block holds
// the cipher while its tag is handed over, and for as long as the tag output
// is stalled. A block accepted into an empty queue is dispatched in the next cycle
// if the cipher is idle and its subkeys are ready. After reset or a key write the
// first block also waits for key expansion, encryption of zero and subkey derivation.
module aes_cmac_tag_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_idx,
    input  wire [63:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [63:0]  i_block_high,
    input  wire [63:0]  i_block_low,
    input  wire [4:0]   i_valid_bytes,
    input  wire         i_last,
    input  wire         i_check,
    input  wire [63:0]  i_expected_high,
    input  wire [63:0]  i_expected_low,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_tag_high,
    output logic [63:0] o_tag_low,
    output logic        o_match
);
    logic [63:0] r_key_high, r_key_low;
    acmac_pkg::t_item w_item, w_q_item;
    logic w_q_valid, w_q_pop;
    logic [127:0] w_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == acmac_pkg::CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
            if (i_cfg_idx == acmac_pkg::CFG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
        end
    end

    assign w_item = '{data: {i_block_high, i_block_low}, valid_bytes: i_valid_bytes,
                      last: i_last, check: i_check,
                      expected: {i_expected_high, i_expected_low}};

    acmac_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(w_item), .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_item(w_q_item)
    );

    acmac_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key({r_key_high, r_key_low}),
        .i_key_wr(i_cfg_we), .i_q_valid(w_q_valid), .o_q_pop(w_q_pop),
        .i_q_item(w_q_item), .o_valid(o_valid), .i_stall(i_stall),
        .o_tag(w_tag), .o_match(o_match)
    );

    assign o_tag_high = w_tag[127:64];
    assign o_tag_low  = w_tag[63:0];
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int  ITEM_TARGET = 1150;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        wr;
        logic        wr_idx;
        logic [63:0] wr_data;
        logic [63:0] bh, bl;
        logic [4:0]  vb;
        logic        last, check;
        logic [63:0] eh, el;
        logic        known;
        logic [63:0] th, tl;
        logic        m;
    } t_row;

    typedef struct {
        logic [63:0] th, tl;
        logic        m;
    } t_tag;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_valid, o_stall;
    logic [63:0] i_block_high, i_block_low;
    logic [4:0]  i_valid_bytes;
    logic        i_last, i_check;
    logic [63:0] i_expected_high, i_expected_low;
    logic        o_valid, i_stall;
    logic [63:0] o_tag_high, o_tag_low;
    logic        o_match;

    aes_cmac_tag_engine uut (.*);

    // predictor state
    logic [7:0]   sb [256];
    logic [127:0] cur_key, chain_q, sub1, sub2;
    logic [127:0] rkeys [11];
    logic         keys_fresh;

    t_tag   pending_tags[$];
    t_row   plan[$];
    int     errors, results, items_sent, key_writes, match_count;
    longint cycles;
    bit     calm;
    int     hold;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic void build_sbox();
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            b = inv;
            sb[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
    endfunction

    function automatic void expand_rkeys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = cur_key[127 - 32 * i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i - 1];
            if (i % 4 == 0) begin
                t = {sb[t[23:16]] ^ rc, sb[t[15:8]], sb[t[7:0]], sb[t[31:24]]};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkeys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] ct;
        for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ rkeys[0][127 - 8 * i -: 8];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++) t[w + 4 * c] = sb[s[w + 4 * ((c + w) % 4)]];
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                if (r == 10) begin
                    s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
                end else begin
                    s[4 * c]     = a0 ^ al ^ gmul(a0 ^ a1, 8'h02);
                    s[4 * c + 1] = a1 ^ al ^ gmul(a1 ^ a2, 8'h02);
                    s[4 * c + 2] = a2 ^ al ^ gmul(a2 ^ a3, 8'h02);
                    s[4 * c + 3] = a3 ^ al ^ gmul(a3 ^ a0, 8'h02);
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= rkeys[r][127 - 8 * i -: 8];
        end
        for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
        return ct;
    endfunction

    function automatic logic [127:0] shift_rb(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
    endfunction

    // returns 1 when the block closes a message, tag holds the cmac
    function automatic logic cmac_block(input logic [127:0] blk, input logic [4:0] vb,
                                        input logic last, output logic [127:0] tag);
        int n;
        tag = '0;
        if (!keys_fresh) begin
            expand_rkeys();
            sub1 = shift_rb(aes_encrypt(128'h0));
            sub2 = shift_rb(sub1);
            keys_fresh = 1'b1;
        end
        if (!last) begin
            chain_q = aes_encrypt(blk ^ chain_q);
            return 1'b0;
        end
        n = (vb > 16) ? 16 : vb;
        if (n == 16) begin
            blk ^= sub1;
        end else begin
            for (int i = 0; i < 16; i++) begin
                if (i == n) blk[127 - 8 * i -: 8] = acmac_pkg::PAD_MARK;
                else if (i > n) blk[127 - 8 * i -: 8] = 8'h00;
            end
            blk ^= sub2;
        end
        tag = aes_encrypt(blk ^ chain_q);
        chain_q = '0;
        return 1'b1;
    endfunction

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_tags.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_key(input logic idx, input logic [63:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx ? acmac_pkg::CFG_KEY_LOW : acmac_pkg::CFG_KEY_HIGH;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx) cur_key[63:0] = val;
        else cur_key[127:64] = val;
        keys_fresh = 1'b0;
        key_writes++;
    endtask

    task automatic send_block(input t_row r);
        int gap;
        logic [127:0] tag;
        t_tag e;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_block_high    <= r.bh;
        i_block_low     <= r.bl;
        i_valid_bytes   <= r.vb;
        i_last          <= r.last;
        i_check         <= r.check;
        i_expected_high <= r.eh;
        i_expected_low  <= r.el;
        if (cmac_block({r.bh, r.bl}, r.vb, r.last, tag)) begin
            if (r.known) begin
                e.th = r.th; e.tl = r.tl; e.m = r.m;
            end else begin
                e.th = tag[127:64]; e.tl = tag[63:0];
                e.m = r.check && (tag == {r.eh, r.el});
            end
            pending_tags.push_back(e);
        end
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    function automatic t_row blk_row(input logic [63:0] bh, input logic [63:0] bl,
                                     input logic [4:0] vb, input logic last,
                                     input logic check, input logic [63:0] eh,
                                     input logic [63:0] el);
        t_row r;
        r = '{default: '0};
        r.bh = bh; r.bl = bl; r.vb = vb; r.last = last; r.check = check;
        r.eh = eh; r.el = el;
        return r;
    endfunction

    function automatic t_row known_row(input t_row r, input logic [63:0] th,
                                       input logic [63:0] tl, input logic m);
        r.known = 1'b1; r.th = th; r.tl = tl; r.m = m;
        return r;
    endfunction

    function automatic t_row key_row(input logic idx, input logic [63:0] val);
        t_row r;
        r = '{default: '0};
        r.wr = 1'b1; r.wr_idx = idx; r.wr_data = val;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_tag e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results++;
                if (pending_tags.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transaction tag=%h%h match=%b",
                                               o_tag_high, o_tag_low, o_match);
                end else begin
                    e = pending_tags.pop_front();
                    if (o_match) match_count++;
                    if (o_tag_high !== e.th || o_tag_low !== e.tl || o_match !== e.m) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp tag=%h%h match=%b got tag=%h%h match=%b",
                                     e.th, e.tl, e.m, o_tag_high, o_tag_low, o_match);
                    end
                end
                hold = calm ? 0 : $urandom_range(0, 9);
            end else if (hold > 0) begin
                hold--;
            end
            i_stall <= (hold > 0);
        end
    end

    initial begin
        t_row r;
        int n;
        logic [127:0] tag;
        logic [63:0] keys_hi [4];
        errors = 0; results = 0; items_sent = 0; key_writes = 0; match_count = 0;
        cycles = 0; calm = 1'b0; hold = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = acmac_pkg::CFG_KEY_HIGH;
        i_cfg_data = '0;
        i_valid = 1'b0; i_block_high = '0; i_block_low = '0; i_valid_bytes = '0;
        i_last = 1'b0; i_check = 1'b0; i_expected_high = '0; i_expected_low = '0;
        build_sbox();
        cur_key = '0; chain_q = '0; keys_fresh = 1'b0;

        // zero key after reset
        plan.push_back(blk_row('0, '0, 5'd0, 1'b1, 1'b0, '0, '0));
        plan.push_back(blk_row('1, '1, acmac_pkg::FULL_BLK, 1'b1, 1'b1, '1, '1));
        plan.push_back(blk_row('1, '1, 5'd0, 1'b0, 1'b1, '1, '1));
        plan.push_back(blk_row(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b1,
                               1'b0, '0, '0));
        plan.push_back(blk_row('1, '1, 5'd1, 1'b1, 1'b0, '0, '0));
        plan.push_back(blk_row('1, '1, 5'd15, 1'b1, 1'b1, '0, '0));
        // standard cmac vectors
        plan.push_back(key_row(1'b0, 64'h2b7e151628aed2a6));
        plan.push_back(key_row(1'b1, 64'habf7158809cf4f3c));
        plan.push_back(known_row(blk_row('0, '0, 5'd0, 1'b1, 1'b1, 64'hbb1d6929e9593728,
                                         64'h7fa37d129b756746),
                                 64'hbb1d6929e9593728, 64'h7fa37d129b756746, 1'b1));
        plan.push_back(known_row(blk_row(64'h6bc1bee22e409f96, 64'he93d7e117393172a,
                                         acmac_pkg::FULL_BLK, 1'b1, 1'b1,
                                         64'h070a16b46b4d4144, 64'hf79bdd9dd04a287d),
                                 64'h070a16b46b4d4144, 64'hf79bdd9dd04a287c, 1'b0));
        plan.push_back(blk_row(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b0,
                               1'b0, '0, '0));
        plan.push_back(blk_row(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd3, 1'b0,
                               1'b0, '0, '0));
        plan.push_back(known_row(blk_row(64'h30c81c46a35ce411, 64'hffffffffffffffff,
                                         5'd8, 1'b1, 1'b0, '0, '0),
                                 64'hdfa66747de9ae630, 64'h30ca32611497c827, 1'b0));
        // key change in the middle of a message keeps the chain
        plan.push_back(blk_row(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd16, 1'b0,
                               1'b0, '0, '0));
        plan.push_back(key_row(1'b1, '1));
        plan.push_back(blk_row(64'h8000000000000001, 64'h1, 5'd16, 1'b1, 1'b1, '0, '0));
        plan.push_back(key_row(1'b0, '1));
        plan.push_back(blk_row('1, '1, 5'd16, 1'b1, 1'b1, '1, '1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].wr) write_key(plan[k].wr_idx, plan[k].wr_data);
            else send_block(plan[k]);
        end

        keys_hi[0] = '1; keys_hi[1] = '0; keys_hi[2] = {$urandom, $urandom};
        keys_hi[3] = 64'h8000000000000000;
        n = 0;
        while (items_sent < ITEM_TARGET) begin
            // new key every few dozen messages, extremes included
            if (n % 40 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                if (n / 40 < 4) begin
                    write_key(1'b0, keys_hi[n / 40]);
                    write_key(1'b1, keys_hi[(n / 40 + 1) % 4]);
                end else begin
                    write_key(1'($urandom_range(0, 1)), {$urandom, $urandom});
                end
            end
            n++;
            for (int b = ($urandom_range(0, 19) == 0) ? 8 : $urandom_range(1, 4); b > 0; b--) begin
                r = blk_row({$urandom, $urandom}, {$urandom, $urandom},
                            5'($urandom_range(0, 31)), b == 1, 1'($urandom_range(0, 1)),
                            {$urandom, $urandom}, {$urandom, $urandom});
                if (r.last && $urandom_range(0, 1)) r.vb = acmac_pkg::FULL_BLK;
                else if (r.last && $urandom_range(0, 3) == 0) r.vb = 5'd0;
                if (r.last && $urandom_range(0, 1)) begin
                    // peek at the tag on a copy of the state to hand in a real mac
                    automatic logic [127:0] c_save = chain_q;
                    automatic logic         f_save = keys_fresh;
                    void'(cmac_block({r.bh, r.bl}, r.vb, 1'b1, tag));
                    chain_q = c_save;
                    keys_fresh = f_save;
                    {r.eh, r.el} = tag ^ ($urandom_range(0, 3) == 0 ?
                                          (128'h1 << $urandom_range(0, 127)) : 128'h0);
                end
                send_block(r);
            end
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (pending_tags.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d blocks sent, %0d tags checked (%0d matched), %0d key writes",
                 items_sent, results, match_count, key_writes);
        $display("covered empty, partial, oversized and full final blocks with random stalls");
        if (errors == 0 && pending_tags.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d tags missing", errors, pending_tags.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
